[design/bbp_pkg.sv]
// shared constants and types for the box blur pixel core
package bbp_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COORD_W     = 8;
    localparam int DIM_W       = 9;
    localparam int RADIUS_W    = 4;
    localparam int CHAN_W      = 8;
    localparam int PIXEL_W     = 3 * CHAN_W;
    localparam int ADDR_W      = 2 * COORD_W;
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    // largest window is 31 x 31 pixels of 255
    localparam int SUM_W       = 18;
    localparam int CNT_W       = 10;
    localparam int SPAN_W      = 5;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_rgb_sum;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

endpackage

[design/bbp_divider.sv]
// iterative restoring divider, three channel sums by one window count
module bbp_divider
    import bbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_rgb_sum         i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output t_rgb             o_quot
);

    typedef struct packed {
        logic [CNT_W-1:0] rem;
        logic [SUM_W-1:0] quot;
    } t_div_lane;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [CNT_W-1:0]   r_divisor;
    t_div_lane          r_lane_r, r_lane_g, r_lane_b;
    t_div_lane          n_lane_r, n_lane_g, n_lane_b;

    // one shift-subtract step
    function automatic t_div_lane div_step(t_div_lane lane, logic [CNT_W-1:0] dvs);
        logic [CNT_W:0] shifted;
        logic [CNT_W:0] diff;
        t_div_lane      res;
        shifted = {lane.rem, lane.quot[SUM_W-1]};
        diff    = shifted - {1'b0, dvs};
        if (shifted >= {1'b0, dvs}) begin
            res.rem  = diff[CNT_W-1:0];
            res.quot = {lane.quot[SUM_W-2:0], 1'b1};
        end else begin
            res.rem  = shifted[CNT_W-1:0];
            res.quot = {lane.quot[SUM_W-2:0], 1'b0};
        end
        return res;
    endfunction

    always_comb begin
        n_lane_r = div_step(r_lane_r, r_divisor);
        n_lane_g = div_step(r_lane_g, r_divisor);
        n_lane_b = div_step(r_lane_b, r_divisor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor     <= i_divisor;
            r_lane_r.rem  <= '0;
            r_lane_r.quot <= i_dividend.red;
            r_lane_g.rem  <= '0;
            r_lane_g.quot <= i_dividend.green;
            r_lane_b.rem  <= '0;
            r_lane_b.quot <= i_dividend.blue;
        end else if (r_busy) begin
            r_lane_r <= n_lane_r;
            r_lane_g <= n_lane_g;
            r_lane_b <= n_lane_b;
        end
    end

    // the mean never exceeds a channel maximum
    assign o_done       = r_done;
    assign o_quot.red   = r_lane_r.quot[CHAN_W-1:0];
    assign o_quot.green = r_lane_g.quot[CHAN_W-1:0];
    assign o_quot.blue  = r_lane_b.quot[CHAN_W-1:0];

endmodule

[design/box_blur_pixel_core.sv]
// box blur pixel core: frame memory, window scan and mean of an rgb888 window
//
// channel   direction  handshake                   payload
// request   in         start & !busy               i_action, i_pos_x/y, i_in_red/green/blue
// result    out        o_valid, one cycle strobe   o_out_red/green/blue, o_bad_position
// config    in         apb, psel&penable&pwrite    img_width 0x0, img_height 0x4, radius 0x8
//
// a store leaves busy low; a blur request outside the image is answered in the
// cycle after it is accepted, also without raising busy
// a blurred request holds busy while the single frame memory read port walks the
// window (one pixel a cycle) and the 18 step divider runs
// reset (synchronous, active low) clears control state and sets the config registers to 256 x 256 and radius 1;
// the frame memory is not cleared, a pixel must be stored before it is read
// results cannot be stalled, each one is shown for exactly one cycle
module box_blur_pixel_core
    import bbp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                start,
    output logic                busy,
    input  logic                i_action,
    input  logic [COORD_W-1:0]  i_pos_x,
    input  logic [COORD_W-1:0]  i_pos_y,
    input  logic [CHAN_W-1:0]   i_in_red,
    input  logic [CHAN_W-1:0]   i_in_green,
    input  logic [CHAN_W-1:0]   i_in_blue,
    // result channel
    output logic                o_valid,
    output logic [CHAN_W-1:0]   o_out_red,
    output logic [CHAN_W-1:0]   o_out_green,
    output logic [CHAN_W-1:0]   o_out_blue,
    output logic                o_bad_position,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // register indexes (word address)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN     = 3'd1;
    localparam logic [2:0] ST_LAST     = 3'd2;
    localparam logic [2:0] ST_DIV_GO   = 3'd3;
    localparam logic [2:0] ST_DIV_WAIT = 3'd4;

    localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [DIM_W-1:0]    r_img_width;
    logic [DIM_W-1:0]    r_img_height;
    logic [RADIUS_W-1:0] r_radius;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= DIM_MAX_W;
            r_img_height <= DIM_MAX_H;
            r_radius     <= RADIUS_W'(1);
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_WIDTH:  r_img_width  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: r_img_height <= pwdata[DIM_W-1:0];
                REG_RADIUS: r_radius     <= pwdata[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, r_img_width};
            REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, r_img_height};
            REG_RADIUS: prdata = {{(32-RADIUS_W){1'b0}}, r_radius};
            default:    prdata = '0;
        endcase
    end

    // effective image size: zero counts as one, anything above the frame as the frame
    logic [DIM_W-1:0] eff_w, eff_h;

    always_comb begin
        if (r_img_width == '0)           eff_w = DIM_W'(1);
        else if (r_img_width > DIM_MAX_W) eff_w = DIM_MAX_W;
        else                             eff_w = r_img_width;
        if (r_img_height == '0)           eff_h = DIM_W'(1);
        else if (r_img_height > DIM_MAX_H) eff_h = DIM_MAX_H;
        else                              eff_h = r_img_height;
    end

    // ---------------------------------------------------------------
    // request decode and window bounds
    // ---------------------------------------------------------------
    logic               req_accept;
    logic               pos_in_image;
    logic [DIM_W-1:0]   x_hi_sum, y_hi_sum, w_last, h_last;
    logic [COORD_W-1:0] win_x0, win_x1, win_y0, win_y1;

    assign req_accept   = start && !busy;
    assign pos_in_image = ({1'b0, i_pos_x} < eff_w) && ({1'b0, i_pos_y} < eff_h);
    assign x_hi_sum     = {1'b0, i_pos_x} + DIM_W'(r_radius);
    assign y_hi_sum     = {1'b0, i_pos_y} + DIM_W'(r_radius);
    assign w_last       = eff_w - 1'b1;
    assign h_last       = eff_h - 1'b1;

    always_comb begin
        win_x0 = (i_pos_x >= COORD_W'(r_radius)) ? i_pos_x - COORD_W'(r_radius) : '0;
        win_y0 = (i_pos_y >= COORD_W'(r_radius)) ? i_pos_y - COORD_W'(r_radius) : '0;
        win_x1 = (x_hi_sum < eff_w) ? x_hi_sum[COORD_W-1:0] : w_last[COORD_W-1:0];
        win_y1 = (y_hi_sum < eff_h) ? y_hi_sum[COORD_W-1:0] : h_last[COORD_W-1:0];
    end

    // ---------------------------------------------------------------
    // frame memory: one write port for stores, one read port for the scan
    // ---------------------------------------------------------------
    logic [PIXEL_W-1:0] frame_mem [0:FRAME_DEPTH-1];
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [PIXEL_W-1:0] r_rd_data;

    assign mem_we    = req_accept && !i_action && pos_in_image;
    assign mem_waddr = {i_pos_y, i_pos_x};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= {i_in_red, i_in_green, i_in_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= frame_mem[mem_raddr];
        end
    end

    // ---------------------------------------------------------------
    // scan sequencer
    // ---------------------------------------------------------------
    logic [2:0]         r_state;
    logic               r_rd_vld;
    logic [COORD_W-1:0] r_x0, r_x1, r_y0, r_y1;
    logic [COORD_W-1:0] r_cx, r_cy;
    t_rgb_sum           r_sum;
    logic               scan_last;
    logic [SPAN_W-1:0]  span_x, span_y;
    logic [CNT_W-1:0]   win_cnt;
    logic               div_start;
    logic               div_done;
    t_rgb               div_quot;

    // a request may only follow once the previous one is fully answered
    assign busy      = (r_state != ST_IDLE);
    assign mem_re    = (r_state == ST_SCAN);
    assign mem_raddr = {r_cy, r_cx};
    assign scan_last = (r_cx == r_x1) && (r_cy == r_y1);
    assign div_start = (r_state == ST_DIV_GO);

    // window pixel count, inclusive on both edges so never zero
    logic [COORD_W-1:0] dx, dy;
    assign dx      = r_x1 - r_x0;
    assign dy      = r_y1 - r_y0;
    assign span_x  = dx[SPAN_W-1:0] + 1'b1;
    assign span_y  = dy[SPAN_W-1:0] + 1'b1;
    assign win_cnt = CNT_W'(span_x) * CNT_W'(span_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= mem_re;
            case (r_state)
                ST_IDLE: begin
                    if (req_accept && i_action && pos_in_image) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_last) begin
                        r_state <= ST_LAST;
                    end
                end
                ST_LAST:     r_state <= ST_DIV_GO;
                ST_DIV_GO:   r_state <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default:     r_state <= ST_IDLE;
            endcase
        end
    end

    // window bounds, walk position and channel sums
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && req_accept) begin
            r_x0  <= win_x0;
            r_x1  <= win_x1;
            r_y0  <= win_y0;
            r_y1  <= win_y1;
            r_cx  <= win_x0;
            r_cy  <= win_y0;
            r_sum <= '0;
        end else begin
            if (mem_re) begin
                // raster walk, row by row
                if (r_cx == r_x1) begin
                    r_cx <= r_x0;
                    r_cy <= r_cy + 1'b1;
                end else begin
                    r_cx <= r_cx + 1'b1;
                end
            end
            if (r_rd_vld) begin
                r_sum.red   <= r_sum.red   + SUM_W'(r_rd_data[23:16]);
                r_sum.green <= r_sum.green + SUM_W'(r_rd_data[15:8]);
                r_sum.blue  <= r_sum.blue  + SUM_W'(r_rd_data[7:0]);
            end
        end
    end

    bbp_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (win_cnt),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic bad_req;
    assign bad_req = (r_state == ST_IDLE) && req_accept && i_action && !pos_in_image;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= bad_req || ((r_state == ST_DIV_WAIT) && div_done);
        end
    end

    always_ff @(posedge i_clk) begin
        if (bad_req) begin
            o_out_red      <= '0;
            o_out_green    <= '0;
            o_out_blue     <= '0;
            o_bad_position <= 1'b1;
        end else if (div_done) begin
            o_out_red      <= div_quot.red;
            o_out_green    <= div_quot.green;
            o_out_blue     <= div_quot.blue;
            o_bad_position <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // the walk never leaves the clamped window
    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cx >= r_x0) && (r_cx <= r_x1)
                                 && (r_cy >= r_y0) && (r_cy <= r_y1))
        else $error("frame read outside the blur window");

    // the divider never sees a zero count
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (win_cnt != '0))
        else $error("divider started with an empty window");

    // a blurred result only ends a divide
    a_blur_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_bad_position) |-> ($past(r_state) == ST_DIV_WAIT))
        else $error("blurred result without a finished divide");

    // an out of image answer carries zero channels
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_position) |->
            (o_out_red == '0) && (o_out_green == '0) && (o_out_blue == '0))
        else $error("bad position result with non-zero channels");

endmodule
